// ===== rtl/core/dkdc_pkg.sv =====
package dkdc_pkg;

  // Field and register widths.
  localparam int SYMBOL_W   = 8;
  localparam int LEN_W      = 5;
  localparam int MOD_W      = 17;
  localparam int PACKED_W   = 62;
  localparam int COUNT_W    = 32;
  localparam int CFG_DATA_W = 17;
  localparam int CFG_IDX_W  = 1;
  localparam int STEP_W     = 6;

  // Default sizes; the first two are handed to the top level parameters.
  localparam int TABLE_SLOTS_DEF      = 65536;
  localparam int MAX_STRING_CHARS_DEF = 31;
  localparam int QUEUE_DEPTH          = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_STRING_LENGTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TABLE_MODULUS = 1'd1;

  // Configuration reset values.
  localparam logic [LEN_W-1:0] STRING_LENGTH_RST = 5'd15;
  localparam logic [MOD_W-1:0] TABLE_MODULUS_RST = 17'd65536;

  // Nucleotide characters; every other byte codes as A.
  localparam logic [SYMBOL_W-1:0] CHAR_C = 8'h43;
  localparam logic [SYMBOL_W-1:0] CHAR_T = 8'h54;
  localparam logic [SYMBOL_W-1:0] CHAR_G = 8'h47;

  localparam logic [1:0] CODE_A = 2'd0;
  localparam logic [1:0] CODE_C = 2'd1;
  localparam logic [1:0] CODE_T = 2'd2;
  localparam logic [1:0] CODE_G = 2'd3;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Status of the back end seen by the front end.
  typedef struct packed {
    logic clearing;
  } back_status_t;

  function automatic logic [1:0] symbol_code(input logic [SYMBOL_W-1:0] s);
    logic [1:0] c;
    unique case (s)
      CHAR_C:  c = CODE_C;
      CHAR_T:  c = CODE_T;
      CHAR_G:  c = CODE_G;
      default: c = CODE_A;
    endcase
    return c;
  endfunction

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    return (v == COUNT_MAX) ? v : v + COUNT_W'(1);
  endfunction

endpackage

// ===== rtl/core/dkdc_if.sv =====
// Symbol channel.
interface dkdc_in_if;
  logic                          valid;
  logic                          ready;
  logic [dkdc_pkg::SYMBOL_W-1:0] symbol;

  modport source (output valid, output symbol, input ready);
  modport sink (input valid, input symbol, output ready);
endinterface

// Result channel, one transaction per completed string.
interface dkdc_out_if;
  logic                         valid;
  logic                         ready;
  logic                         was_seen;
  logic [dkdc_pkg::COUNT_W-1:0] distinct_count;
  logic [dkdc_pkg::COUNT_W-1:0] total_count;

  modport source (output valid, output was_seen, output distinct_count,
                  output total_count, input ready);
  modport sink (input valid, input was_seen, input distinct_count,
                input total_count, output ready);
endinterface

// ===== rtl/core/dkdc_front.sv =====
module dkdc_front (
  input  logic                              clk,
  input  logic                              rst,
  dkdc_in_if.sink                           symbols,
  input  logic [dkdc_pkg::LEN_W-1:0]        eff_len,
  input  dkdc_pkg::back_status_t            status,
  input  logic                              q_full,
  output logic                              push,
  output logic [dkdc_pkg::PACKED_W-1:0]     push_data
);

  logic [dkdc_pkg::LEN_W-1:0]    pos;
  logic [dkdc_pkg::PACKED_W-1:0] packed_value;
  logic [dkdc_pkg::PACKED_W-1:0] packed_next;
  logic [dkdc_pkg::PACKED_W-1:0] code_shifted;
  logic                          accept;
  logic                          last_char;

  // Hold off symbols while the table is being cleared or the queue is full.
  assign symbols.ready = !status.clearing && !q_full;
  assign accept        = symbols.valid && symbols.ready;

  // Each position owns its own two bits, so placing the code is an OR.
  assign code_shifted = dkdc_pkg::PACKED_W'(dkdc_pkg::symbol_code(symbols.symbol))
                        << {pos, 1'b0};
  assign packed_next  = packed_value | code_shifted;

  // A string ends once the symbol count reaches the current length.
  assign last_char = ({1'b0, pos} + 6'd1) >= {1'b0, eff_len};

  assign push      = accept && last_char;
  assign push_data = packed_next;

  // Position and packed value of the string in progress.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos          <= '0;
      packed_value <= '0;
    end else if (accept) begin
      if (last_char) begin
        pos          <= '0;
        packed_value <= '0;
      end else begin
        pos          <= pos + dkdc_pkg::LEN_W'(1);
        packed_value <= packed_next;
      end
    end
  end

endmodule

// ===== rtl/core/dkdc_fifo.sv =====
module dkdc_fifo #(
  parameter int WIDTH = dkdc_pkg::PACKED_W,
  parameter int DEPTH = dkdc_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = entries[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/core/dkdc_back.sv =====
module dkdc_back #(
  parameter int TABLE_SLOTS = dkdc_pkg::TABLE_SLOTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [dkdc_pkg::MOD_W-1:0]        eff_mod,
  input  logic                              q_empty,
  input  logic [dkdc_pkg::PACKED_W-1:0]     q_data,
  output logic                              pop,
  dkdc_out_if.source                        results,
  output dkdc_pkg::back_status_t            status
);

  localparam int SLOT_W = $clog2(TABLE_SLOTS);
  localparam int MOD_W  = dkdc_pkg::MOD_W;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_READ,
    S_CHECK
  } state_t;

  state_t                          state;
  logic [SLOT_W-1:0]               clr_cnt;
  logic [dkdc_pkg::PACKED_W-1:0]   dividend;
  logic [MOD_W-1:0]                rem;
  logic [MOD_W:0]                  trial;
  logic [MOD_W-1:0]                rem_next;
  logic [dkdc_pkg::STEP_W-1:0]     step;
  logic [MOD_W+SLOT_W-1:0]         rem_wide;
  logic [SLOT_W-1:0]               slot;

  logic                            bitmap [TABLE_SLOTS];
  logic                            wr_en;
  logic [SLOT_W-1:0]               wr_addr;
  logic                            wr_data;
  logic                            rd_bit;

  logic                            out_valid;
  logic                            out_was_seen;
  logic [dkdc_pkg::COUNT_W-1:0]    distinct;
  logic [dkdc_pkg::COUNT_W-1:0]    total;
  logic                            out_free;
  logic                            finish;

  assign status.clearing = (state == S_CLEAR);
  assign pop             = (state == S_IDLE) && !q_empty;

  // One restoring remainder step: shift in the next dividend bit.
  assign trial    = {rem, dividend[dkdc_pkg::PACKED_W-1]};
  assign rem_next = (trial >= {1'b0, eff_mod}) ? MOD_W'(trial - {1'b0, eff_mod})
                                               : trial[MOD_W-1:0];

  // The remainder is below the modulus, which never exceeds the table size.
  assign rem_wide = {{SLOT_W{1'b0}}, rem};
  assign slot     = rem_wide[SLOT_W-1:0];

  assign out_free = !out_valid || results.ready;
  assign finish   = (state == S_CHECK) && out_free;

  // Table write port: zeros during the clearing pass, then marks new slots.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = slot;
    wr_data = 1'b1;
    if (state == S_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_cnt;
      wr_data = 1'b0;
    end else if (finish && !rd_bit) begin
      wr_en = 1'b1;
    end
  end

  // Seen table with registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      bitmap[wr_addr] <= wr_data;
    end
    rd_bit <= bitmap[slot];
  end

  // Sequencer, remainder unit, counters and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      step      <= '0;
      out_valid <= 1'b0;
      distinct  <= '0;
      total     <= '0;
    end else begin
      if (out_valid && results.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + SLOT_W'(1);
          if (clr_cnt == SLOT_W'(TABLE_SLOTS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (!q_empty) begin
            dividend <= q_data;
            rem      <= '0;
            step     <= '0;
            state    <= S_DIV;
          end
        end
        S_DIV: begin
          rem      <= rem_next;
          dividend <= dividend << 1;
          step     <= step + dkdc_pkg::STEP_W'(1);
          if (step == dkdc_pkg::STEP_W'(dkdc_pkg::PACKED_W - 1)) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            out_was_seen <= rd_bit;
            if (!rd_bit) begin
              distinct <= dkdc_pkg::sat_inc(distinct);
            end
            total <= dkdc_pkg::sat_inc(total);
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign results.valid          = out_valid;
  assign results.was_seen       = out_was_seen;
  assign results.distinct_count = distinct;
  assign results.total_count    = total;

  // No result can be pending while the table is still being cleared.
  a_no_result_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !out_valid)
    else $error("result pending during table clear");

  // The partial remainder stays below the modulus.
  a_rem_below_mod: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV || state == S_READ || state == S_CHECK) |-> (rem < eff_mod))
    else $error("remainder not below modulus");

  // Distinct strings never outnumber completed strings.
  a_counts_ordered: assert property (@(posedge clk) disable iff (rst)
    distinct <= total)
    else $error("distinct count above total count");

  // A result that was shown stays until it is taken.
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !results.ready) |=> (out_valid && $stable(total)))
    else $error("pending result dropped or changed");

endmodule

// ===== rtl/core/dna_kmer_duplicate_counter_core.sv =====
// Nucleotide string duplicate counter. Symbols (ASCII, C=1, T=2, G=3,
// anything else 0) arrive one per transaction and every string_length of
// them form one string. The front end packs a string at one symbol per
// cycle while the queue has room and hands it through a two-entry queue
// to the back end. The back end takes a string from the queue, reduces
// the 62-bit packed value modulo table_modulus with a one-bit-per-cycle
// remainder unit, then reads and marks the seen table; it waits in its
// check state while the result channel stalls. Since a string has at
// most 31 symbols, the back end always sets the sustained rate, with the
// queue absorbing short bursts. Symbols stall while the queue is full.
// Each completed string yields one result with was_seen and saturating
// distinct and total counts. After reset the seen table is cleared one
// slot per cycle, and no symbol is accepted while it is cleared;
// configuration writes are taken at any time.
module dna_kmer_duplicate_counter_core #(
  parameter int TABLE_SLOTS      = dkdc_pkg::TABLE_SLOTS_DEF,
  parameter int MAX_STRING_CHARS = dkdc_pkg::MAX_STRING_CHARS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  dkdc_in_if.sink                            symbols,
  dkdc_out_if.source                         results,
  input  logic                               cfg_we,
  input  logic [dkdc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dkdc_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int MOD_W = dkdc_pkg::MOD_W;
  localparam logic [MOD_W-1:0] SLOTS_CAP =
    (TABLE_SLOTS > 131071) ? {MOD_W{1'b1}} : MOD_W'(TABLE_SLOTS);
  localparam logic [dkdc_pkg::LEN_W-1:0] LEN_CAP =
    dkdc_pkg::LEN_W'(MAX_STRING_CHARS);

  logic [dkdc_pkg::LEN_W-1:0]    string_length;
  logic [MOD_W-1:0]              table_modulus;
  logic [dkdc_pkg::LEN_W-1:0]    eff_len;
  logic [MOD_W-1:0]              eff_mod;

  dkdc_pkg::back_status_t        status;
  logic                          push;
  logic [dkdc_pkg::PACKED_W-1:0] push_data;
  logic                          q_full;
  logic                          q_empty;
  logic                          pop;
  logic [dkdc_pkg::PACKED_W-1:0] q_data;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      string_length <= dkdc_pkg::STRING_LENGTH_RST;
      table_modulus <= dkdc_pkg::TABLE_MODULUS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dkdc_pkg::REG_STRING_LENGTH: string_length <= cfg_data[dkdc_pkg::LEN_W-1:0];
        dkdc_pkg::REG_TABLE_MODULUS: table_modulus <= cfg_data[MOD_W-1:0];
        default: ;
      endcase
    end
  end

  // Zero means one; values past the limits saturate.
  always_comb begin
    priority if (string_length == '0) begin
      eff_len = dkdc_pkg::LEN_W'(1);
    end else if (string_length > LEN_CAP) begin
      eff_len = LEN_CAP;
    end else begin
      eff_len = string_length;
    end
    priority if (table_modulus == '0) begin
      eff_mod = MOD_W'(1);
    end else if (table_modulus > SLOTS_CAP) begin
      eff_mod = SLOTS_CAP;
    end else begin
      eff_mod = table_modulus;
    end
  end

  dkdc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .symbols   (symbols),
    .eff_len   (eff_len),
    .status    (status),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  dkdc_fifo #(
    .WIDTH (dkdc_pkg::PACKED_W),
    .DEPTH (dkdc_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (q_data),
    .empty     (q_empty)
  );

  dkdc_back #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .eff_mod (eff_mod),
    .q_empty (q_empty),
    .q_data  (q_data),
    .pop     (pop),
    .results (results),
    .status  (status)
  );

endmodule

// ===== tb/sv/tb_dna_kmer_duplicate_counter_core.sv =====
module tb_dna_kmer_duplicate_counter_core;
  import dkdc_pkg::*;

  localparam int CLK_PERIOD     = 10;
  localparam int RESET_CYCLES   = 9;
  // Idle time after the last report, with margin over the back end's work per string.
  localparam int DRAIN_CYCLES   = 120;
  localparam int TIMEOUT_CYCLES = 1_000_000;
  localparam int RANDOM_PHASES  = 16;
  localparam int POOL_SIZE      = 16;

  localparam logic [SYMBOL_W-1:0] CHAR_A = 8'h41;
  localparam logic [3:0][SYMBOL_W-1:0] NUCLEOTIDES = {CHAR_G, CHAR_T, CHAR_C, CHAR_A};

  // One result transaction as seen on the output channel.
  typedef struct packed {
    logic               was_seen;
    logic [COUNT_W-1:0] distinct_count;
    logic [COUNT_W-1:0] total_count;
  } dup_report_t;

  typedef enum logic {ROW_SYMBOL, ROW_WRITE} row_kind_e;

  // A directed row either writes a register or sends one symbol. Where typed is
  // set, the report given here replaces the predicted one.
  typedef struct packed {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] value;
    logic                  typed;
    dup_report_t           report;
  } plan_row_t;

  localparam dup_report_t NO_REPORT = '0;

  localparam plan_row_t DIRECTED_PLAN [29] = '{
    // A full string at the reset length, with extreme and non-nucleotide bytes.
    '{ROW_SYMBOL, '0, 17'(CHAR_G), 1'b0, NO_REPORT},
    '{ROW_SYMBOL, '0, 17'h00,      1'b0, NO_REPORT},
    '{ROW_SYMBOL, '0, 17'hFF,      1'b0, NO_REPORT},
    '{ROW_SYMBOL, '0, 17'h61,      1'b0, NO_REPORT},  // lowercase a
    '{ROW_SYMBOL, '0, 17'h63,      1'b0, NO_REPORT},  // lowercase c
    '{ROW_SYMBOL, '0, 17'(CHAR_T), 1'b0, NO_REPORT},
    '{ROW_SYMBOL, '0, 17'(CHAR_C), 1'b0, NO_REPORT},
    '{ROW_SYMBOL, '0, 17'(CHAR_A), 1'b0, NO_REPORT},
    '{ROW_SYMBOL, '0, 17'h80,      1'b0, NO_REPORT},
    '{ROW_SYMBOL, '0, 17'h7F,      1'b0, NO_REPORT},
    '{ROW_SYMBOL, '0, 17'(CHAR_G), 1'b0, NO_REPORT},
    '{ROW_SYMBOL, '0, 17'(CHAR_G), 1'b0, NO_REPORT},
    '{ROW_SYMBOL, '0, 17'(CHAR_T), 1'b0, NO_REPORT},
    '{ROW_SYMBOL, '0, 17'(CHAR_C), 1'b0, NO_REPORT},
    '{ROW_SYMBOL, '0, 17'(CHAR_G), 1'b1, '{1'b0, 32'd1, 32'd1}},
    // Zero length (upper data bits set) acts as one; zero modulus acts as one.
    '{ROW_WRITE, REG_STRING_LENGTH, 17'h1FFE0, 1'b0, NO_REPORT},
    '{ROW_WRITE, REG_TABLE_MODULUS, 17'd0,     1'b0, NO_REPORT},
    '{ROW_SYMBOL, '0, 17'(CHAR_A), 1'b1, '{1'b0, 32'd2, 32'd2}},
    '{ROW_SYMBOL, '0, 17'(CHAR_G), 1'b1, '{1'b1, 32'd2, 32'd3}},
    // Modulus above the table size saturates; slots 1 and 2 are still clear.
    '{ROW_WRITE, REG_TABLE_MODULUS, 17'h1FFFF, 1'b0, NO_REPORT},
    '{ROW_SYMBOL, '0, 17'(CHAR_T), 1'b1, '{1'b0, 32'd3, 32'd4}},
    '{ROW_SYMBOL, '0, 17'(CHAR_C), 1'b1, '{1'b0, 32'd4, 32'd5}},
    '{ROW_SYMBOL, '0, 17'(CHAR_C), 1'b1, '{1'b1, 32'd4, 32'd6}},
    '{ROW_SYMBOL, '0, 17'h67,      1'b1, '{1'b1, 32'd4, 32'd7}},  // lowercase g
    // Shortening the length mid-string ends the string at the next symbol.
    '{ROW_WRITE, REG_STRING_LENGTH, 17'd4, 1'b0, NO_REPORT},
    '{ROW_SYMBOL, '0, 17'(CHAR_C), 1'b0, NO_REPORT},
    '{ROW_SYMBOL, '0, 17'(CHAR_G), 1'b0, NO_REPORT},
    '{ROW_WRITE, REG_STRING_LENGTH, 17'd2, 1'b0, NO_REPORT},
    '{ROW_SYMBOL, '0, 17'(CHAR_T), 1'b0, NO_REPORT}
  };

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  dkdc_in_if  sym_ch ();
  dkdc_out_if res_ch ();

  dna_kmer_duplicate_counter_core DUT (
    .clk       (clk),
    .rst       (rst),
    .symbols   (sym_ch),
    .results   (res_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow copy of the counter state.
  logic [LEN_W-1:0]    shadow_length;
  logic [MOD_W-1:0]    shadow_modulus;
  logic [PACKED_W-1:0] kmer_acc;
  logic [LEN_W-1:0]    kmer_pos;
  bit                  seen_slots [TABLE_SLOTS_DEF];
  logic [COUNT_W-1:0]  distinct_seen;
  logic [COUNT_W-1:0]  strings_done;

  dup_report_t pending_reports [$];
  int          send_idle_pct;
  int          recv_stall_pct;
  int          failures;

  logic [30:0][SYMBOL_W-1:0] string_pool [POOL_SIZE];
  int                        pool_fill;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Adds one symbol to the current string; returns 1 with the report when the
  // string completes.
  function automatic bit predict_kmer_step(input logic [SYMBOL_W-1:0] sym,
                                           output dup_report_t rep);
    logic [1:0]          code;
    logic [LEN_W-1:0]    eff_len;
    logic [MOD_W-1:0]    eff_mod;
    logic [PACKED_W-1:0] slot;
    case (sym)
      CHAR_C:  code = CODE_C;
      CHAR_T:  code = CODE_T;
      CHAR_G:  code = CODE_G;
      default: code = CODE_A;
    endcase
    eff_len = (shadow_length == 0) ? LEN_W'(1) : shadow_length;
    if (eff_len > MAX_STRING_CHARS_DEF) eff_len = LEN_W'(MAX_STRING_CHARS_DEF);
    eff_mod = (shadow_modulus == 0) ? MOD_W'(1) : shadow_modulus;
    if (eff_mod > TABLE_SLOTS_DEF) eff_mod = MOD_W'(TABLE_SLOTS_DEF);
    rep = NO_REPORT;
    kmer_acc = kmer_acc + (PACKED_W'(code) << (2 * kmer_pos));
    if (kmer_pos + 1 < eff_len) begin
      kmer_pos = kmer_pos + 1'b1;
      return 1'b0;
    end
    slot = kmer_acc % PACKED_W'(eff_mod);
    rep.was_seen = seen_slots[int'(slot)];
    seen_slots[int'(slot)] = 1'b1;
    if (!rep.was_seen && distinct_seen != COUNT_MAX) distinct_seen = distinct_seen + 1'b1;
    if (strings_done != COUNT_MAX) strings_done = strings_done + 1'b1;
    rep.distinct_count = distinct_seen;
    rep.total_count = strings_done;
    kmer_acc = '0;
    kmer_pos = '0;
    return 1'b1;
  endfunction

  function automatic void note_failure(input string msg);
    failures++;
    if (failures <= 10) $display("%s", msg);
  endfunction

  // Sends one symbol with a random leading gap and records the expected report.
  task automatic send_symbol(input logic [SYMBOL_W-1:0] sym, input logic use_typed,
                             input dup_report_t typed_rep);
    dup_report_t rep;
    while ($urandom_range(99) < send_idle_pct) begin
      sym_ch.valid <= 1'b0;
      @(posedge clk);
    end
    sym_ch.valid  <= 1'b1;
    sym_ch.symbol <= sym;
    @(posedge clk);
    while (sym_ch.ready !== 1'b1) @(posedge clk);
    if (predict_kmer_step(sym, rep)) begin
      if (use_typed) rep = typed_rep;
      pending_reports = {pending_reports, rep};
    end
  endtask

  // Waits for every outstanding report, then lets the back end go quiet.
  task automatic wait_until_drained();
    sym_ch.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    if (idx == REG_STRING_LENGTH) shadow_length = data[LEN_W-1:0];
    else if (idx == REG_TABLE_MODULUS) shadow_modulus = data[MOD_W-1:0];
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Result transactions are compared field by field with the oldest report.
  task automatic check_report();
    dup_report_t want;
    if (pending_reports.size() == 0) begin
      note_failure($sformatf("unexpected result: was_seen=%0b distinct=%0d total=%0d",
                             res_ch.was_seen, res_ch.distinct_count, res_ch.total_count));
    end else begin
      want = pending_reports.pop_front();
      if (res_ch.was_seen !== want.was_seen)
        note_failure($sformatf("was_seen: expected %0b, got %0b",
                               want.was_seen, res_ch.was_seen));
      if (res_ch.distinct_count !== want.distinct_count)
        note_failure($sformatf("distinct_count: expected %0d, got %0d",
                               want.distinct_count, res_ch.distinct_count));
      if (res_ch.total_count !== want.total_count)
        note_failure($sformatf("total_count: expected %0d, got %0d",
                               want.total_count, res_ch.total_count));
    end
  endtask

  // Result side: random stalls on ready, checking at each accepted transaction.
  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) check_report();
      res_ch.ready <= !rst && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Stimulus.
  initial begin
    int                        n_items;
    logic [LEN_W-1:0]          len_pick;
    logic [MOD_W-1:0]          mod_pick;
    logic [30:0][SYMBOL_W-1:0] cur_string;

    shadow_length  = STRING_LENGTH_RST;
    shadow_modulus = TABLE_MODULUS_RST;
    kmer_acc       = '0;
    kmer_pos       = '0;
    distinct_seen  = '0;
    strings_done   = '0;
    failures       = 0;
    pool_fill      = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    cur_string     = '0;
    foreach (seen_slots[i]) seen_slots[i] = 1'b0;

    rst           <= 1'b1;
    cfg_we        <= 1'b0;
    cfg_index     <= '0;
    cfg_data      <= '0;
    sym_ch.valid  <= 1'b0;
    sym_ch.symbol <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed rows; the first symbol waits out the table clearing pass.
    foreach (DIRECTED_PLAN[i]) begin
      if (DIRECTED_PLAN[i].kind == ROW_WRITE) begin
        wait_until_drained();
        write_register(DIRECTED_PLAN[i].reg_idx, DIRECTED_PLAN[i].value);
      end else begin
        send_symbol(DIRECTED_PLAN[i].value[SYMBOL_W-1:0], DIRECTED_PLAN[i].typed,
                    DIRECTED_PLAN[i].report);
      end
    end

    // Random phases; each may write new settings and picks an idling mode.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      wait_until_drained();
      case ($urandom_range(9))
        0:       len_pick = '0;
        1:       len_pick = LEN_W'(MAX_STRING_CHARS_DEF);
        2, 3, 4: len_pick = LEN_W'($urandom_range(1, 4));
        default: len_pick = LEN_W'($urandom_range(5, 12));
      endcase
      case ($urandom_range(9))
        0:       mod_pick = '0;
        1:       mod_pick = MOD_W'(1);
        2, 3:    mod_pick = MOD_W'($urandom_range(2, 16));
        4:       mod_pick = MOD_W'(TABLE_SLOTS_DEF);
        5:       mod_pick = MOD_W'($urandom_range(TABLE_SLOTS_DEF + 1, 131071));
        6:       mod_pick = MOD_W'($urandom_range(17, 1024));
        default: mod_pick = MOD_W'($urandom_range(1, TABLE_SLOTS_DEF));
      endcase
      if (ph == 0 || $urandom_range(4) != 0)
        write_register(REG_STRING_LENGTH, {12'($urandom), len_pick});
      if (ph == 0 || $urandom_range(4) != 0)
        write_register(REG_TABLE_MODULUS, mod_pick);
      case (ph % 4)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 66; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 66; end
        default: begin send_idle_pct = 33; recv_stall_pct = 33; end
      endcase
      n_items = $urandom_range(80, 114);
      repeat (n_items) begin
        // A new string either repeats an earlier one or is fresh, mostly
        // nucleotides with a few arbitrary bytes mixed in.
        if (kmer_pos == 0) begin
          if (pool_fill != 0 && $urandom_range(99) < 35) begin
            cur_string = string_pool[$urandom_range(pool_fill - 1)];
          end else begin
            for (int k = 0; k < 31; k++)
              cur_string[k] = ($urandom_range(9) == 0) ? SYMBOL_W'($urandom)
                                                       : NUCLEOTIDES[$urandom_range(3)];
            if (pool_fill < POOL_SIZE) begin
              string_pool[pool_fill] = cur_string;
              pool_fill++;
            end else begin
              string_pool[$urandom_range(POOL_SIZE - 1)] = cur_string;
            end
          end
        end
        send_symbol(cur_string[kmer_pos], 1'b0, NO_REPORT);
      end
    end

    wait_until_drained();
    if (failures == 0) begin
      $display("dna_kmer_duplicate_counter_core test passed");
    end else begin
      $display("dna_kmer_duplicate_counter_core test failed");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("dna_kmer_duplicate_counter_core test failed");
    $finish;
  end

endmodule
